// ===== hw/rtl/tglt_pkg.sv =====
package tglt_pkg;

  localparam int TRACK_WIDTH   = 10;
  localparam int LAP_WIDTH     = 32;
  localparam int COUNT_WIDTH   = 16;
  localparam int SPEED_WIDTH   = 28;
  localparam int PRODUCT_WIDTH = 20;

  localparam logic [TRACK_WIDTH-1:0]   TRACK_RESET = 10'd30;
  localparam logic [PRODUCT_WIDTH-1:0] SPEED_SCALE = 20'd1000;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } race_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_BEST,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic best;
    logic div_step;
    logic div_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic lap_nonzero;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/tglt_ctrl.sv =====
module tglt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tglt_pkg::cmd_t cmd,
  input  tglt_pkg::sts_t sts
);
  import tglt_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.finish ? S_BEST : S_DONE;
      end
      S_BEST: begin
        cmd.best   = 1'b1;
        state_next = sts.lap_nonzero ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || !out_stall)
    else $error("output register overwritten while held");
`endif

endmodule

// ===== hw/rtl/tglt_datapath.sv =====
module tglt_datapath #(
  parameter int TIME_WIDTH          = 32,
  parameter int SPEED_FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tglt_pkg::cmd_t                        cmd,
  output tglt_pkg::sts_t                        sts,
  input  logic                                  op,
  input  logic                                  start_gate,
  input  logic                                  finish_gate,
  input  logic                                  cfg_valid,
  input  logic [tglt_pkg::TRACK_WIDTH-1:0]      cfg_data,
  output logic                                  lap_done,
  output logic [tglt_pkg::COUNT_WIDTH-1:0]      lap_count,
  output logic [tglt_pkg::LAP_WIDTH-1:0]        last_lap_ms,
  output logic [tglt_pkg::LAP_WIDTH-1:0]        best_lap_ms,
  output logic [tglt_pkg::SPEED_WIDTH-1:0]      speed_q8
);
  import tglt_pkg::*;

  localparam int NUM_W = PRODUCT_WIDTH + SPEED_FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [TIME_WIDTH-1:0]  now_ms;
  logic [TIME_WIDTH-1:0]  lap_start_ms;
  logic [LAP_WIDTH-1:0]   last_lap;
  logic [LAP_WIDTH-1:0]   best_lap;
  logic [COUNT_WIDTH-1:0] laps;
  logic [SPEED_WIDTH-1:0] speed_value;
  logic                   prev_start_level;
  logic                   prev_finish_level;
  logic [TRACK_WIDTH-1:0] track_length_cm;
  logic                   is_clear;
  logic                   is_start;
  logic                   is_finish;

  logic [LAP_WIDTH-1:0]   rem;
  logic [NUM_W-1:0]       quo;
  logic [LAP_WIDTH-1:0]   divisor;
  logic [CNT_W-1:0]       div_cnt;

  logic [TIME_WIDTH-1:0]    lap_diff;
  logic [LAP_WIDTH-1:0]     lap32;
  logic [PRODUCT_WIDTH-1:0] product;
  logic [NUM_W-1:0]         numerator;
  logic [LAP_WIDTH:0]       shifted;
  logic [LAP_WIDTH+1:0]     trial;
  logic                     borrow;
  logic [SPEED_WIDTH-1:0]   speed_sat;
  logic                     start_edge;

  assign lap_diff = now_ms - lap_start_ms;

  if (TIME_WIDTH > LAP_WIDTH) begin : g_lap_sat
    assign lap32 = (|lap_diff[TIME_WIDTH-1:LAP_WIDTH]) ? '1 : lap_diff[LAP_WIDTH-1:0];
  end else begin : g_lap_ext
    assign lap32 = LAP_WIDTH'(lap_diff);
  end

  if (NUM_W > SPEED_WIDTH) begin : g_speed_sat
    assign speed_sat = (|quo[NUM_W-1:SPEED_WIDTH]) ? '1 : quo[SPEED_WIDTH-1:0];
  end else begin : g_speed_ext
    assign speed_sat = SPEED_WIDTH'(quo);
  end

  assign product   = PRODUCT_WIDTH'(track_length_cm) * SPEED_SCALE;
  assign numerator = NUM_W'(product) << SPEED_FRACTION_BITS;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem, quo[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign borrow  = trial[LAP_WIDTH+1];

  assign start_edge = !start_gate && prev_start_level;

  assign sts.finish      = is_finish;
  assign sts.lap_nonzero = (last_lap != '0);
  assign sts.div_last    = (div_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length_cm <= TRACK_RESET;
    end else if (cfg_valid) begin
      track_length_cm <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms            <= '0;
      lap_start_ms      <= '0;
      last_lap          <= '0;
      best_lap          <= '0;
      laps              <= '0;
      speed_value       <= '0;
      prev_start_level  <= 1'b1;
      prev_finish_level <= 1'b1;
      is_clear          <= 1'b0;
      is_start          <= 1'b0;
      is_finish         <= 1'b0;
    end else begin
      if (cmd.load) begin
        is_clear <= (op == OP_CLEAR);
        if (op == OP_CLEAR) begin
          is_start  <= 1'b0;
          is_finish <= 1'b0;
        end else begin
          now_ms            <= now_ms + TIME_WIDTH'(1);
          is_start          <= start_edge;
          // start edge wins over a finish edge on the same tick
          is_finish         <= !finish_gate && prev_finish_level && !start_edge;
          prev_start_level  <= start_gate;
          prev_finish_level <= finish_gate;
        end
      end
      if (cmd.eval) begin
        if (is_clear) begin
          laps         <= '0;
          lap_start_ms <= '0;
          last_lap     <= '0;
          best_lap     <= '0;
          speed_value  <= '0;
        end else if (is_start) begin
          lap_start_ms <= now_ms;
        end else if (is_finish) begin
          if (laps != '1) begin
            laps <= laps + COUNT_WIDTH'(1);
          end
          last_lap <= lap32;
        end
      end
      if (cmd.best) begin
        if (last_lap == '0) begin
          speed_value <= '0;
        end else if (best_lap == '0 || last_lap < best_lap) begin
          best_lap <= last_lap;
        end
      end
      if (cmd.div_fin) begin
        speed_value <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best) begin
      divisor <= last_lap;
      quo     <= numerator;
      rem     <= '0;
      div_cnt <= CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem     <= borrow ? shifted[LAP_WIDTH-1:0] : trial[LAP_WIDTH-1:0];
      quo     <= {quo[NUM_W-2:0], !borrow};
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      lap_done    <= is_finish;
      lap_count   <= laps;
      last_lap_ms <= last_lap;
      best_lap_ms <= best_lap;
      speed_q8    <= speed_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_best_min: assert property (@(posedge clk) disable iff (rst)
    cmd.best && last_lap != '0 |=> best_lap != '0 && best_lap <= last_lap)
    else $error("best lap above last nonzero lap");

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> div_cnt != '0)
    else $error("divider stepped past its last bit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> divisor != '0)
    else $error("divider running on a zero lap time");
`endif

endmodule

// ===== hw/rtl/two_gate_lap_timer_core.sv =====
// Two-gate lap timer core.
// Input channel (in_valid / in_stall): one item per transfer; op = 0 is a
// one-millisecond tick carrying the active-low start_gate and finish_gate
// levels, op = 1 clears the race values. Every item yields exactly one
// result on the output channel (out_valid / out_stall) with lap_done,
// lap_count, last_lap_ms, best_lap_ms and speed_q8.
// Configuration (cfg_valid / cfg_ready / cfg_data): track length in cm,
// always ready; write it only while no item is in work.
// From an input transfer to out_valid the controller steps through
// S_EVAL and S_DONE for a clear or plain tick, S_EVAL, S_BEST and S_DONE
// for a finish with zero lap time, and S_EVAL, S_BEST, S_DIV, S_FIN and
// S_DONE for a finished lap, where the bit-serial speed divider produces
// one quotient bit per cycle. One item is in work at a time; the next is
// taken in the cycle in which out_valid goes high.
// The output register holds a result while out_stall is high; a finished
// item waits in the controller until that register frees up.
// Reset (rst, synchronous) clears time, laps and race values, sets both
// gate levels idle high and the track length to 30 cm.
module two_gate_lap_timer_core #(
  parameter int TIME_WIDTH          = 32,
  parameter int SPEED_FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic                               start_gate,
  input  logic                               finish_gate,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               lap_done,
  output logic [tglt_pkg::COUNT_WIDTH-1:0]   lap_count,
  output logic [tglt_pkg::LAP_WIDTH-1:0]     last_lap_ms,
  output logic [tglt_pkg::LAP_WIDTH-1:0]     best_lap_ms,
  output logic [tglt_pkg::SPEED_WIDTH-1:0]   speed_q8,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tglt_pkg::TRACK_WIDTH-1:0]   cfg_data
);
  import tglt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tglt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tglt_datapath #(
    .TIME_WIDTH          (TIME_WIDTH),
    .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .start_gate  (start_gate),
    .finish_gate (finish_gate),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .lap_done    (lap_done),
    .lap_count   (lap_count),
    .last_lap_ms (last_lap_ms),
    .best_lap_ms (best_lap_ms),
    .speed_q8    (speed_q8)
  );

endmodule
